// ===== hdl/assert_macros.svh =====
// Assertion helpers used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert that a property holds on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Assert that a property holds, with no reset qualification.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hdl/bfpa_pkg.sv =====
// ----------------------------------------------------------------------------
// bfpa_pkg
// Types and codes shared by the best-fit partition allocator.
// ----------------------------------------------------------------------------
package bfpa_pkg;

  localparam logic       CMD_ALLOC   = 1'b0;
  localparam logic       CMD_RELEASE = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_NOID  = 2'd3;

  localparam logic [15:0] TOTAL_SIZE_RESET = 16'd1024;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_SCAN,
    OP_INSERT,
    OP_CLAIM,
    OP_FREE,
    OP_MERGE_NEXT,
    OP_MERGE_PREV
  } op_t;

  typedef struct packed {
    logic init;
    logic load;
    op_t  op;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic found;
    logic need_split;
    logic table_full;
    logic move_done;
    logic next_free;
    logic prev_free;
  } dp_status_t;

endpackage

// ===== hdl/bfpa_datapath.sv =====
// ----------------------------------------------------------------------------
// bfpa_datapath
// Partition table, scan unit and entry shifter of the allocator.
// ----------------------------------------------------------------------------
module bfpa_datapath
  import bfpa_pkg::*;
#(
  parameter int MAX_PARTS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [15:0]      total_size,
  input  dp_cmd_t          cmd,
  input  logic             command,
  input  logic [7:0]       process_id,
  input  logic [15:0]      need_size,
  output dp_status_t       sts,
  output logic [15:0]      hit_start
);

  localparam int IW = $clog2(MAX_PARTS);
  localparam int CW = $clog2(MAX_PARTS + 1);

  logic [15:0]   part_start [MAX_PARTS];
  logic [16:0]   part_size  [MAX_PARTS];
  logic [7:0]    part_owner [MAX_PARTS];
  logic [MAX_PARTS-1:0] part_free;
  logic [CW-1:0] part_count;

  logic          req_cmd;
  logic [7:0]    req_id;
  logic [15:0]   req_need;
  logic [CW-1:0] scan_idx;
  logic [IW-1:0] hit_idx;
  logic          found;
  logic          scan_done;
  logic [CW-1:0] mv_idx;
  logic          move_done;
  logic          merging;

  logic [IW-1:0] si;
  logic          match;
  logic          better;
  logic [CW-1:0] hit_ext;

  assign si      = scan_idx[IW-1:0];
  assign hit_ext = CW'(hit_idx);
  assign match   = (req_cmd == CMD_ALLOC)
                   ? (part_free[si] && (req_need != 16'd0) &&
                      (part_size[si] >= {1'b0, req_need}))
                   : (!part_free[si] && (part_owner[si] == req_id));
  assign better  = !found ||
                   ((req_cmd == CMD_ALLOC) && (part_size[si] < part_size[hit_idx]));

  assign sts.scan_done  = scan_done;
  assign sts.found      = found;
  assign sts.need_split = part_size[hit_idx] > {1'b0, req_need};
  assign sts.table_full = part_count >= CW'(MAX_PARTS);
  assign sts.move_done  = move_done;
  assign sts.next_free  = (hit_ext + CW'(1) < part_count) &&
                          part_free[IW'(hit_ext + CW'(1))];
  assign sts.prev_free  = (hit_idx != '0) && part_free[hit_idx - IW'(1)];
  assign hit_start      = part_start[hit_idx];

  always_ff @(posedge clk) begin
    if (rst || cmd.init) begin
      part_start[0] <= '0;
      part_size[0]  <= rst ? {1'b0, TOTAL_SIZE_RESET} : {1'b0, total_size};
      part_free     <= {{(MAX_PARTS-1){1'b0}}, 1'b1};
      part_count    <= CW'(1);
      scan_done     <= 1'b0;
      found         <= 1'b0;
      move_done     <= 1'b0;
      merging       <= 1'b0;
      hit_idx       <= '0;
    end else if (cmd.load) begin
      req_cmd   <= command;
      req_id    <= process_id;
      req_need  <= need_size;
      scan_idx  <= '0;
      found     <= 1'b0;
      hit_idx   <= '0;
      scan_done <= 1'b0;
      move_done <= 1'b0;
      merging   <= 1'b0;
    end else begin
      unique case (cmd.op)
        OP_SCAN: begin
          if (scan_idx >= part_count || (found && req_cmd == CMD_RELEASE)) begin
            scan_done <= 1'b1;
          end else begin
            if (match && better) begin
              found   <= 1'b1;
              hit_idx <= si;
            end
            scan_idx <= scan_idx + CW'(1);
          end
          mv_idx <= part_count;
        end
        OP_INSERT: begin
          if (move_done) begin
            move_done <= 1'b0;
          end else if (mv_idx > hit_ext + CW'(1)) begin
            part_start[IW'(mv_idx)] <= part_start[IW'(mv_idx - CW'(1))];
            part_size[IW'(mv_idx)]  <= part_size[IW'(mv_idx - CW'(1))];
            part_free[IW'(mv_idx)]  <= part_free[IW'(mv_idx - CW'(1))];
            part_owner[IW'(mv_idx)] <= part_owner[IW'(mv_idx - CW'(1))];
            mv_idx <= mv_idx - CW'(1);
          end else begin
            part_start[IW'(hit_ext + CW'(1))] <= part_start[hit_idx] + req_need;
            part_size[IW'(hit_ext + CW'(1))]  <= part_size[hit_idx] - {1'b0, req_need};
            part_free[IW'(hit_ext + CW'(1))]  <= 1'b1;
            part_size[hit_idx]  <= {1'b0, req_need};
            part_free[hit_idx]  <= 1'b0;
            part_owner[hit_idx] <= req_id;
            part_count <= part_count + CW'(1);
            move_done  <= 1'b1;
          end
        end
        OP_CLAIM: begin
          part_free[hit_idx]  <= 1'b0;
          part_owner[hit_idx] <= req_id;
        end
        OP_FREE: begin
          part_free[hit_idx] <= 1'b1;
        end
        OP_MERGE_NEXT, OP_MERGE_PREV: begin
          if (move_done) begin
            move_done <= 1'b0;
          end else if (!merging) begin
            if (cmd.op == OP_MERGE_NEXT) begin
              part_size[hit_idx] <= part_size[hit_idx] + part_size[IW'(hit_ext + CW'(1))];
              mv_idx <= hit_ext + CW'(1);
            end else begin
              part_size[hit_idx - IW'(1)] <= part_size[hit_idx - IW'(1)] + part_size[hit_idx];
              mv_idx  <= hit_ext;
              hit_idx <= hit_idx - IW'(1);
            end
            merging <= 1'b1;
          end else if (mv_idx + CW'(1) < part_count) begin
            part_start[IW'(mv_idx)] <= part_start[IW'(mv_idx + CW'(1))];
            part_size[IW'(mv_idx)]  <= part_size[IW'(mv_idx + CW'(1))];
            part_free[IW'(mv_idx)]  <= part_free[IW'(mv_idx + CW'(1))];
            part_owner[IW'(mv_idx)] <= part_owner[IW'(mv_idx + CW'(1))];
            mv_idx <= mv_idx + CW'(1);
          end else begin
            part_count <= part_count - CW'(1);
            merging    <= 1'b0;
            move_done  <= 1'b1;
          end
        end
        default: begin
          move_done <= 1'b0;
        end
      endcase
    end
  end

endmodule

// ===== hdl/bfpa_ctrl.sv =====
// ----------------------------------------------------------------------------
// bfpa_ctrl
// Sequencer for request scan, table update and result hand-off.
// ----------------------------------------------------------------------------
module bfpa_ctrl
  import bfpa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        command,
  input  dp_status_t  sts,
  input  logic [15:0] hit_start,
  output dp_cmd_t     cmd,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [15:0] start_address
);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_SPLIT, S_CLAIM, S_FREE, S_MNEXT, S_MPREV, S_DONE
  } state_t;

  state_t state;
  logic   is_rel;

  assign in_stall = (state != S_IDLE) || out_valid || cfg_we;

  always_comb begin
    cmd.init = cfg_we;
    cmd.load = in_valid && !in_stall;
    unique case (state)
      S_SCAN:         cmd.op = OP_SCAN;
      S_SPLIT:        cmd.op = OP_INSERT;
      S_CLAIM:        cmd.op = OP_CLAIM;
      S_FREE:         cmd.op = OP_FREE;
      S_MNEXT:        cmd.op = OP_MERGE_NEXT;
      S_MPREV:        cmd.op = OP_MERGE_PREV;
      S_IDLE, S_DONE: cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      is_rel    <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cmd.load) begin
            is_rel <= command;
            state  <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (sts.scan_done) begin
            if (!sts.found) begin
              status        <= is_rel ? ST_NOID : ST_NOFIT;
              start_address <= '0;
              state         <= S_DONE;
            end else if (is_rel) begin
              status        <= ST_OK;
              start_address <= hit_start;
              state         <= S_FREE;
            end else if (sts.need_split && sts.table_full) begin
              status        <= ST_FULL;
              start_address <= '0;
              state         <= S_DONE;
            end else begin
              status        <= ST_OK;
              start_address <= hit_start;
              state         <= sts.need_split ? S_SPLIT : S_CLAIM;
            end
          end
        end
        S_SPLIT: if (sts.move_done) state <= S_DONE;
        S_CLAIM: state <= S_DONE;
        S_FREE:  state <= sts.next_free ? S_MNEXT : (sts.prev_free ? S_MPREV : S_DONE);
        S_MNEXT: if (sts.move_done) state <= sts.prev_free ? S_MPREV : S_DONE;
        S_MPREV: if (sts.move_done) state <= S_DONE;
        S_DONE: begin
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hdl/best_fit_partition_allocator_top.sv =====
// Best-fit partition allocator: one result per request, one request at a time.
// The table scan checks each table entry in turn. A split and each merge with a
// free neighbor shift the entries after it by one place, an exact fit or a
// release marks one entry, and out_valid is raised from S_DONE. A new
// request is taken only after the result has been accepted. A cfg_we write
// reinitializes the table to one free partition of size cfg_wdata.
// ----------------------------------------------------------------------------
// best_fit_partition_allocator_top
// Top level of the best-fit partition allocator.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module best_fit_partition_allocator_top
  import bfpa_pkg::*;
#(
  parameter int MAX_PARTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        command,
  input  logic [7:0]  process_id,
  input  logic [15:0] need_size,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [15:0] start_address
);

  dp_cmd_t     cmd;
  dp_status_t  sts;
  logic [15:0] hit_start;

  bfpa_datapath #(.MAX_PARTS(MAX_PARTS)) u_dp (
    .clk, .rst, .total_size(cfg_wdata), .cmd, .command, .process_id,
    .need_size, .sts, .hit_start
  );

  bfpa_ctrl u_ctrl (
    .clk, .rst, .cfg_we, .in_valid, .in_stall, .command, .sts, .hit_start,
    .cmd, .out_valid, .out_stall, .status, .start_address
  );

  `ASSERT_CLK(a_no_accept_busy, clk, rst, out_valid |-> in_stall, "accept while result pending")
  `ASSERT_CLK(a_stall_holds, clk, rst, (out_valid && out_stall) |=> out_valid, "result dropped")

endmodule

// ===== bench/tb_best_fit_partition_allocator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Best-fit partition allocator testbench
// Drives allocate and release transactions through the valid/stall channels,
// predicts each result from a local model of the partition table and checks
// status and start address in order, under random idling on both sides.
// ----------------------------------------------------------------------------
module tb_best_fit_partition_allocator_top;
  import bfpa_pkg::*;

  localparam int NUM_PARTS = 16;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    logic        cmd;
    logic [7:0]  id;
    logic [15:0] need;
  } request_t;

  typedef struct {
    logic [1:0]  st;
    logic [15:0] addr;
  } answer_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic        command;
  logic [7:0]  process_id;
  logic [15:0] need_size;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  status;
  logic [15:0] start_address;

  request_t    request_q[$];
  answer_t     answer_q[$];
  request_t    cur_req;
  bit          req_taken;
  int          send_idle_pct;
  int          recv_idle_pct;
  bit          sender_hold;
  bit          long_stall_req;
  int          long_stall_left;
  int          mismatches;
  int          quiet_cycles;
  int          cur_total;

  logic [15:0] tbl_start[NUM_PARTS];
  logic [16:0] tbl_size[NUM_PARTS];
  bit          tbl_free[NUM_PARTS];
  logic [7:0]  tbl_owner[NUM_PARTS];
  int          tbl_count;

  best_fit_partition_allocator_top #(.MAX_PARTS(NUM_PARTS)) i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .command(command),
    .process_id(process_id), .need_size(need_size), .out_valid(out_valid),
    .out_stall(out_stall), .status(status), .start_address(start_address)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void reset_table(int total);
    for (int i = 0; i < NUM_PARTS; i++) begin
      tbl_start[i] = '0;
      tbl_size[i]  = '0;
      tbl_free[i]  = 1'b0;
      tbl_owner[i] = '0;
    end
    tbl_size[0] = total[16:0];
    tbl_free[0] = 1'b1;
    tbl_count   = 1;
  endfunction

  function automatic void drop_entry(int k);
    for (int i = k; i + 1 < tbl_count; i++) begin
      tbl_start[i] = tbl_start[i + 1];
      tbl_size[i]  = tbl_size[i + 1];
      tbl_free[i]  = tbl_free[i + 1];
      tbl_owner[i] = tbl_owner[i + 1];
    end
    tbl_count--;
  endfunction

  function automatic answer_t allocator_answer(request_t r);
    answer_t a;
    int      best;
    bit      found;
    a.st = ST_OK;
    a.addr = '0;
    best = 0;
    found = 1'b0;
    if (r.cmd == CMD_ALLOC) begin
      if (r.need != 0) begin
        for (int i = 0; i < tbl_count; i++) begin
          if (tbl_free[i] && tbl_size[i] >= {1'b0, r.need} &&
              (!found || tbl_size[i] < tbl_size[best])) begin
            best = i;
            found = 1'b1;
          end
        end
      end
      if (!found) begin
        a.st = ST_NOFIT;
        return a;
      end
      if (tbl_size[best] > {1'b0, r.need}) begin
        if (tbl_count >= NUM_PARTS) begin
          a.st = ST_FULL;
          return a;
        end
        for (int j = tbl_count; j > best + 1; j--) begin
          tbl_start[j] = tbl_start[j - 1];
          tbl_size[j]  = tbl_size[j - 1];
          tbl_free[j]  = tbl_free[j - 1];
          tbl_owner[j] = tbl_owner[j - 1];
        end
        tbl_start[best + 1] = tbl_start[best] + r.need;
        tbl_size[best + 1]  = tbl_size[best] - r.need;
        tbl_free[best + 1]  = 1'b1;
        tbl_owner[best + 1] = '0;
        tbl_size[best]      = {1'b0, r.need};
        tbl_count++;
      end
      tbl_free[best]  = 1'b0;
      tbl_owner[best] = r.id;
      a.addr = tbl_start[best];
    end else begin
      for (int i = 0; i < tbl_count; i++) begin
        if (!tbl_free[i] && tbl_owner[i] == r.id) begin
          best = i;
          found = 1'b1;
          break;
        end
      end
      if (!found) begin
        a.st = ST_NOID;
        return a;
      end
      a.addr = tbl_start[best];
      tbl_free[best]  = 1'b1;
      tbl_owner[best] = '0;
      if (best + 1 < tbl_count && tbl_free[best + 1]) begin
        tbl_size[best] = tbl_size[best] + tbl_size[best + 1];
        drop_entry(best + 1);
      end
      if (best > 0 && tbl_free[best - 1]) begin
        tbl_size[best - 1] = tbl_size[best - 1] + tbl_size[best];
        drop_entry(best);
      end
    end
    return a;
  endfunction

  function automatic request_t make_req(logic cmd, int id, int need);
    request_t r;
    r.cmd  = cmd;
    r.id   = id[7:0];
    r.need = need[15:0];
    return r;
  endfunction

  function automatic request_t random_req();
    request_t r;
    int       pick;
    int       tenth;
    r.cmd = ($urandom_range(99) < 40) ? CMD_RELEASE : CMD_ALLOC;
    r.id  = ($urandom_range(99) < 85) ? 8'($urandom_range(7)) : 8'($urandom_range(255));
    tenth = (cur_total / 10 > 1) ? cur_total / 10 : 1;
    pick  = $urandom_range(99);
    if (pick < 60)
      r.need = 16'($urandom_range(tenth, 1));
    else if (pick < 80)
      r.need = 16'($urandom_range((cur_total > 1) ? cur_total : 1, 1));
    else if (pick < 92)
      r.need = 16'($urandom_range(65535, 1));
    else
      r.need = ($urandom_range(1) == 1) ? 16'hffff : 16'h0001;
    return r;
  endfunction

  always @(posedge clk) begin
    bit busy_seen;
    if (!rst) begin
      busy_seen = 1'b0;
      if (in_valid && !in_stall) begin
        answer_q.push_back(allocator_answer(cur_req));
        req_taken = 1'b1;
        busy_seen = 1'b1;
      end
      if (out_valid && !out_stall) begin
        busy_seen = 1'b1;
        if (answer_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: status %0d addr %0d", status, start_address);
        end else begin
          answer_t e;
          e = answer_q.pop_front();
          if (status !== e.st || start_address !== e.addr) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected status %0d addr %0d, got status %0d addr %0d",
                       e.st, e.addr, status, start_address);
          end
        end
      end
      if (answer_q.size() == 0 && request_q.size() == 0 && !in_valid)
        busy_seen = 1'b1;
      if (busy_seen)
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("best_fit_partition_allocator_top test failed");
        $finish;
      end
    end
  end

  // advance the sender on the falling edge
  always @(negedge clk) begin
    if (!rst && (!in_valid || req_taken)) begin
      req_taken = 1'b0;
      if (request_q.size() > 0 && !sender_hold && $urandom_range(99) >= send_idle_pct) begin
        cur_req = request_q.pop_front();
        command    <= cur_req.cmd;
        process_id <= cur_req.id;
        need_size  <= cur_req.need;
        in_valid   <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (long_stall_req) begin
      long_stall_req = 1'b0;
      long_stall_left = 400;
    end
    if (long_stall_left > 0) begin
      long_stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic wait_drained();
    wait (request_q.size() == 0 && !in_valid && answer_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_total(int value);
    wait_drained();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value[15:0];
    @(negedge clk);
    cfg_we    <= 1'b0;
    cur_total = value;
    reset_table(value);
  endtask

  task automatic run_random(int n, int s_pct, int r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int i = 0; i < n; i++)
      request_q.push_back(random_req());
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    command = CMD_ALLOC;
    process_id = '0;
    need_size = '0;
    out_stall = 1'b0;
    req_taken = 1'b0;
    sender_hold = 1'b0;
    long_stall_req = 1'b0;
    long_stall_left = 0;
    mismatches = 0;
    quiet_cycles = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    cur_total = TOTAL_SIZE_RESET;
    reset_table(TOTAL_SIZE_RESET);
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    request_q.push_back(make_req(CMD_ALLOC, 255, 1024));
    request_q.push_back(make_req(CMD_ALLOC, 1, 1));
    request_q.push_back(make_req(CMD_RELEASE, 255, 0));
    request_q.push_back(make_req(CMD_ALLOC, 0, 65535));
    for (int k = 0; k < 15; k++)
      request_q.push_back(make_req(CMD_ALLOC, k, 10));
    request_q.push_back(make_req(CMD_ALLOC, 20, 5));
    request_q.push_back(make_req(CMD_ALLOC, 21, 874));
    request_q.push_back(make_req(CMD_RELEASE, 3, 0));
    request_q.push_back(make_req(CMD_RELEASE, 4, 0));
    request_q.push_back(make_req(CMD_RELEASE, 2, 0));
    request_q.push_back(make_req(CMD_RELEASE, 6, 0));
    request_q.push_back(make_req(CMD_RELEASE, 5, 0));
    request_q.push_back(make_req(CMD_RELEASE, 3, 0));
    request_q.push_back(make_req(CMD_ALLOC, 7, 20));
    request_q.push_back(make_req(CMD_RELEASE, 7, 0));

    write_total(65535);
    run_random(250, 28, 46);
    wait (request_q.size() < 200);
    long_stall_req = 1'b1;
    wait_drained();
    run_random(200, 28, 46);

    write_total(1);
    run_random(120, 46, 28);
    write_total(300);
    run_random(300, 46, 28);

    write_total(1024);
    run_random(240, 0, 0);
    wait (request_q.size() < 120);
    sender_hold = 1'b1;
    wait (answer_q.size() == 0 && !in_valid);
    @(negedge clk);
    sender_hold = 1'b0;
    run_random(240, 0, 0);

    wait_drained();
    if (mismatches == 0)
      $display("best_fit_partition_allocator_top test passed");
    else
      $display("best_fit_partition_allocator_top test failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/bfpa_pkg.sv
hdl/bfpa_datapath.sv
hdl/bfpa_ctrl.sv
hdl/best_fit_partition_allocator_top.sv
bench/tb_best_fit_partition_allocator_top.sv
